>>> rtl/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue.
// Included by the top level only; expects clk_i and rst_ni in scope.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Check on every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, operation and status codes,
// beat and entry types. No dependencies.
package spq_pkg;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] job_id;
    logic [7:0]  prio;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        head_valid;
    logic [15:0] head_job;
    logic [7:0]  head_prio;
    logic [7:0]  count;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] job;
    logic [7:0]  prio;
  } entry_t;

endpackage

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue: top level with entry memory, scan sequencer and
// result register. Depends on spq_pkg and sorted_priority_queue_defines.svh.
//
//   channel | valid       | stall       | beat
//   --------+-------------+-------------+---------------------------------
//   input   | in_valid_i  | in_stall_o  | in_beat_i  (kind, job_id, prio)
//   output  | out_valid_o | out_stall_i | out_beat_o (status, head, count)
//
// Entries live sorted in one memory with a registered read; an insert, delete
// or remove that scans walks it one entry per cycle via one write and one read port.
// Refused and no-op beats go straight to the result state; the input opens
// again once the result register is loaded.
// Reset clears fill, sequencer and result valid; memory contents need none.
// A stalled output holds its result while the next beat is already taken.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::in_beat_t in_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::out_beat_t out_beat_o
);

  localparam int unsigned AW = spq_pkg::AW;
  localparam int unsigned CW = spq_pkg::CW;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_INS      = 5'b00010,
    S_INS_LAST = 5'b00100,
    S_DEL      = 5'b01000,
    S_DONE     = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] pos_q, pos_d;     // insert: target slot; delete: index of read data
  logic          found_q, found_d;
  logic [15:0]   job_q, job_d;
  logic [7:0]    prio_q, prio_d;
  logic [1:0]    status_q, status_d;
  spq_pkg::entry_t head_q, head_d;

  logic               out_valid_q, out_valid_d;
  spq_pkg::out_beat_t out_q, out_d;
  logic               out_load;

  // Entry memory: one write and one registered read per cycle.
  spq_pkg::entry_t mem_q [spq_pkg::DEPTH];
  spq_pkg::entry_t mem_rd_q;
  logic            mem_we;
  logic [CW-1:0]   wr_idx, rd_idx;
  spq_pkg::entry_t mem_wd;

  logic hit, last;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx[AW-1:0]] <= mem_wd;
    end
    mem_rd_q <= mem_q[rd_idx[AW-1:0]];
  end

  // Sequencer. Reads always run ahead of writes (insert reads slot-2 while
  // writing slot, delete reads i+1 while writing i-1), so the read and write
  // addresses of one cycle never meet and no forwarding is needed.
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    found_d   = found_q;
    job_d     = job_q;
    prio_d    = prio_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    wr_idx    = '0;
    rd_idx    = '0;
    mem_wd    = '0;
    out_load  = 1'b0;
    hit       = !found_q && (mem_rd_q.job == job_q);
    last      = ((pos_q + CW'(1)) == fill_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          job_d  = in_beat_i.job_id;
          prio_d = in_beat_i.prio;
          unique case (in_beat_i.kind)
            spq_pkg::KIND_INSERT: begin
              if (fill_q == CW'(spq_pkg::DEPTH)) begin
                status_d = spq_pkg::ST_FULL;
                state_d  = S_DONE;
              end else if (fill_q == '0) begin
                pos_d   = '0;
                state_d = S_INS_LAST;
              end else begin
                // Start the backward scan at the last entry.
                pos_d   = fill_q;
                rd_idx  = fill_q - CW'(1);
                state_d = S_INS;
              end
            end
            spq_pkg::KIND_DELETE: begin
              if (fill_q == '0) begin
                status_d = spq_pkg::ST_EMPTY;
                state_d  = S_DONE;
              end else if (fill_q == CW'(1)) begin
                fill_d   = '0;
                status_d = spq_pkg::ST_OK;
                state_d  = S_DONE;
              end else begin
                // Head is the victim: shift from entry one downward.
                found_d = 1'b1;
                pos_d   = CW'(1);
                rd_idx  = CW'(1);
                state_d = S_DEL;
              end
            end
            spq_pkg::KIND_REMOVE: begin
              if (fill_q == '0) begin
                status_d = spq_pkg::ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                found_d = 1'b0;
                pos_d   = '0;
                rd_idx  = '0;
                state_d = S_DEL;
              end
            end
            default: begin
              status_d = spq_pkg::ST_OK;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      S_INS: begin
        // mem_rd_q holds the entry at pos_q - 1.
        mem_we = 1'b1;
        wr_idx = pos_q;
        if (mem_rd_q.prio > prio_q) begin
          mem_wd = mem_rd_q;
          pos_d  = pos_q - CW'(1);
          if (pos_q == CW'(1)) begin
            state_d = S_INS_LAST;
          end else begin
            rd_idx = pos_q - CW'(2);
          end
        end else begin
          mem_wd   = '{job: job_q, prio: prio_q};
          fill_d   = fill_q + CW'(1);
          status_d = spq_pkg::ST_OK;
          state_d  = S_DONE;
        end
      end

      S_INS_LAST: begin
        mem_we   = 1'b1;
        wr_idx   = pos_q;
        mem_wd   = '{job: job_q, prio: prio_q};
        fill_d   = fill_q + CW'(1);
        status_d = spq_pkg::ST_OK;
        state_d  = S_DONE;
      end

      S_DEL: begin
        // mem_rd_q holds the entry at pos_q; past the victim, move it down one.
        if (found_q) begin
          mem_we = 1'b1;
          wr_idx = pos_q - CW'(1);
          mem_wd = mem_rd_q;
        end
        found_d = found_q || hit;
        if (!last) begin
          pos_d  = pos_q + CW'(1);
          rd_idx = pos_q + CW'(1);
        end else begin
          if (found_q || hit) begin
            fill_d   = fill_q - CW'(1);
            status_d = spq_pkg::ST_OK;
          end else begin
            status_d = spq_pkg::ST_NOTFOUND;
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the result register is free or draining.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Cached head: refresh on every write to slot zero.
  always_comb begin
    head_d = head_q;
    if (mem_we && (wr_idx == '0)) begin
      head_d = mem_wd;
    end
  end

  always_comb begin
    out_d.status     = status_q;
    out_d.head_valid = (fill_q != '0);
    out_d.head_job   = (fill_q != '0) ? head_q.job : '0;
    out_d.head_prio  = (fill_q != '0) ? head_q.prio : '0;
    out_d.count      = 8'(fill_q);
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    found_q  <= found_d;
    job_q    <= job_d;
    prio_q   <= prio_d;
    status_q <= status_d;
    head_q   <= head_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `SPQ_ASSERT(a_fill_bound, fill_q <= CW'(spq_pkg::DEPTH), "fill exceeds depth")
  `SPQ_ASSERT(a_accept_closes, in_valid_i && !in_stall_o |=> in_stall_o, "input open after accept")
  `SPQ_ASSERT(a_idle_no_write, state_q == S_IDLE |-> !mem_we, "memory written while idle")
  `SPQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_q, "result valid in reset")

endmodule

>>> verif/spq_checker.sv
// Checker for the sorted priority queue: watches both channels, mirrors the queue
// contents on every accepted request beat and compares every accepted result beat.
// Depends on spq_pkg only.
module spq_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  spq_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  spq_pkg::out_beat_t out_beat_i,
  output int                 mismatches_o,
  output int                 outstanding_o
);

  spq_pkg::entry_t    held [spq_pkg::DEPTH];
  int unsigned        fill;
  spq_pkg::out_beat_t pending_results [$];
  spq_pkg::out_beat_t want;
  spq_pkg::out_beat_t got;

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    fill          = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, seen, wanted);
    mismatches_o++;
  endtask

  // Close the gap left by the entry at pos.
  task automatic drop_entry(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < fill; i++) held[i] = held[i + 1];
    fill--;
  endtask

  // Apply one request to the mirrored queue and return the result it must produce.
  task automatic apply_queue_op(input spq_pkg::in_beat_t req,
                                output spq_pkg::out_beat_t res);
    int unsigned pos;
    logic        hit;
    res        = '0;
    res.status = spq_pkg::ST_OK;
    case (req.kind)
      spq_pkg::KIND_INSERT: begin
        if (fill >= spq_pkg::DEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          pos = fill;
          while (pos > 0 && held[pos - 1].prio > req.prio) begin
            held[pos] = held[pos - 1];
            pos--;
          end
          held[pos].job  = req.job_id;
          held[pos].prio = req.prio;
          fill++;
        end
      end
      spq_pkg::KIND_DELETE: begin
        if (fill == 0) res.status = spq_pkg::ST_EMPTY;
        else drop_entry(0);
      end
      spq_pkg::KIND_REMOVE: begin
        if (fill == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          hit = 1'b0;
          for (pos = 0; pos < fill && !hit; pos++) begin
            if (held[pos].job == req.job_id) begin
              hit = 1'b1;
              drop_entry(pos);
            end
          end
          if (!hit) res.status = spq_pkg::ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    if (fill > 0) begin
      res.head_valid = 1'b1;
      res.head_job   = held[0].job;
      res.head_prio  = held[0].prio;
    end
    res.count = 8'(fill);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_results.delete();
      fill          = 0;
      outstanding_o = 0;
    end else begin
      // Retire the result first: it always belongs to an earlier request.
      if (out_valid_i && !out_stall_i) begin
        got = out_beat_i;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request waiting", got, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.head_valid !== want.head_valid)
            report_mismatch("head_valid", got.head_valid, want.head_valid);
          if (got.head_job !== want.head_job)
            report_mismatch("head_job", got.head_job, want.head_job);
          if (got.head_prio !== want.head_prio)
            report_mismatch("head_prio", got.head_prio, want.head_prio);
          if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_queue_op(in_beat_i, want);
        pending_results.push_back(want);
      end
      outstanding_o = pending_results.size();
    end
  end

endmodule

>>> verif/testbench.sv
// Top of the sorted priority queue testbench: clock, reset, request stimulus,
// result stall pattern and verdict. Depends on spq_pkg, sorted_priority_queue, spq_checker.
module testbench;

  // The fourth kind code is unused by the block and must act as a no-op.
  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASE_ITEMS  = 200;
  // Longest operation walks the whole memory; leave room for a stray result.
  localparam int SETTLE_CYCLES = 2 * spq_pkg::DEPTH + 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  spq_pkg::in_beat_t  in_beat_i;
  logic               out_valid_o;
  logic               out_stall_i;
  spq_pkg::out_beat_t out_beat_o;

  int   mismatches;
  int   outstanding;
  int   idle_pct;
  int   stall_pct;
  logic hold_req;

  sorted_priority_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  spq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_beat_i     (in_beat_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_beat_i    (out_beat_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or loses a result.
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: stall at the current rate; on request hold off for a long
  // stretch so the block fills its output and then stalls the request side.
  initial begin
    int held;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one request beat, idling first at the current rate, and hold it
  // until the block takes it. Valid stays up into the next beat, so it is
  // only ever lowered by an idle cycle or an explicit pause.
  task automatic send_request(input logic [1:0] kind, input logic [15:0] job,
                              input logic [7:0] prio);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_beat_i.kind   <= kind;
    in_beat_i.job_id <= job;
    in_beat_i.prio   <= prio;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Random traffic. Job numbers mostly come from a small pool so removes hit,
  // priorities mostly from a narrow band so ties are common; full-range values
  // still show up to toggle every bit. Grow mode favors inserts, else deletes.
  task automatic run_random(input int items, input logic grow);
    int          pick;
    logic [1:0]  kind;
    logic [15:0] job;
    logic [7:0]  prio;
    repeat (items) begin
      pick = int'($urandom_range(99));
      if (pick < 3)                     kind = KIND_NOP;
      else if (pick < (grow ? 75 : 30)) kind = spq_pkg::KIND_INSERT;
      else if (pick < (grow ? 88 : 65)) kind = spq_pkg::KIND_DELETE;
      else                              kind = spq_pkg::KIND_REMOVE;
      job  = 16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(31));
      prio = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7));
      send_request(kind, job, prio);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i  = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-queue refusals and the no-op kind.
    send_request(spq_pkg::KIND_DELETE, 16'h0000, 8'h00);
    send_request(spq_pkg::KIND_REMOVE, 16'hffff, 8'hff);
    send_request(KIND_NOP,             16'hffff, 8'hff);
    // Extremes of job and priority; the zero priority must take the head.
    send_request(spq_pkg::KIND_INSERT, 16'hffff, 8'hff);
    send_request(spq_pkg::KIND_INSERT, 16'h0000, 8'h00);
    // Equal priorities must leave in arrival order; duplicate job number too.
    send_request(spq_pkg::KIND_INSERT, 16'h1234, 8'h80);
    send_request(spq_pkg::KIND_INSERT, 16'h5555, 8'h80);
    send_request(spq_pkg::KIND_INSERT, 16'haaaa, 8'h80);
    send_request(spq_pkg::KIND_INSERT, 16'h0000, 8'h80);
    // Remove from the middle, an absent job, then the first of two matches.
    send_request(spq_pkg::KIND_REMOVE, 16'h5555, 8'h00);
    send_request(spq_pkg::KIND_REMOVE, 16'h7777, 8'h00);
    send_request(spq_pkg::KIND_REMOVE, 16'h0000, 8'hff);
    // No-op on a populated queue; deletes with junk in the ignored fields.
    send_request(KIND_NOP,             16'h0000, 8'h00);
    send_request(spq_pkg::KIND_DELETE, 16'hffff, 8'hff);
    send_request(spq_pkg::KIND_REMOVE, 16'hffff, 8'h00);
    send_request(spq_pkg::KIND_DELETE, 16'h5a5a, 8'ha5);
    send_request(spq_pkg::KIND_DELETE, 16'h0000, 8'h00);
    send_request(spq_pkg::KIND_DELETE, 16'h0000, 8'h00);
    send_request(spq_pkg::KIND_REMOVE, 16'h0000, 8'h00);
    wait_drained();

    // Back-to-back traffic with no idling on either side.
    run_random(PHASE_ITEMS, 1'b1);
    // Fill past capacity while the result side holds off: the block backs
    // up, then every extra insert must come back refused as full.
    hold_req = 1'b1;
    repeat (spq_pkg::DEPTH + 6)
      send_request(spq_pkg::KIND_INSERT, 16'($urandom_range(65535)),
                   8'($urandom_range(255)));

    idle_pct  = 66;
    stall_pct = 0;
    run_random(PHASE_ITEMS, 1'b0);
    wait_drained();

    idle_pct  = 0;
    stall_pct = 66;
    run_random(PHASE_ITEMS, 1'b1);
    // Drain to empty and past it.
    repeat (spq_pkg::DEPTH + 4)
      send_request(spq_pkg::KIND_DELETE, 16'($urandom_range(65535)),
                   8'($urandom_range(255)));

    idle_pct  = 38;
    stall_pct = 38;
    run_random(PHASE_ITEMS / 2, 1'b1);
    run_random(PHASE_ITEMS / 2, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
